FILE: src/ufc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufc_pkg
// Types, constants and the CRC-16 byte update for the update frame checker.
// ----------------------------------------------------------------------------
package ufc_pkg;

  localparam int unsigned MIN_FRAME = 10;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [7:0]  HEADER_RESET = 8'd238;
  localparam int unsigned DELAY_DEPTH  = 4;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_SHORT      = 2'd1,
    STATUS_BAD_HEADER = 2'd2,
    STATUS_CRC_FAIL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  packet_number;
    logic [7:0]  packet_total;
    logic [15:0] payload_length;
    logic [15:0] received_check;
    logic [15:0] computed_check;
    logic        reply_sent;
    logic        reply_ok;
    logic        started_flag;
    logic        update_complete;
  } result_t;

  // reflected CRC-16, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/update_frame_checker_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// update_frame_checker_crc16
// Checks framed update packets: header, minimum frame length and CRC-16, one verdict
// per frame, with sticky started / completed flags.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------
//  item     | item_valid, item_stall   | ufc_pkg::item_t
//  result   | result_valid, result_stall | ufc_pkg::result_t
//  cfg      | cfg_valid, cfg_ready     | cfg_data (header byte)
//
// One byte per cycle while the input does not stall. An accepted byte is first
// held in the input register; the CRC, frame state and result register then update
// together when it fires, so result_valid rises once the last byte leaves that register.
// Synchronous reset clears frame state, sticky flags and header_byte to 238.
// The input stalls only when a last byte meets a full, stalled result.
module update_frame_checker_crc16 (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  ufc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output ufc_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data
);
  import ufc_pkg::*;

  logic [7:0]  header_byte;
  logic        in_valid;
  item_t       in_item;
  logic [15:0] byte_count;
  logic [7:0]  delay_line [DELAY_DEPTH];
  logic [15:0] running_crc;
  logic        header_match;
  logic [7:0]  header_fields [4];
  logic        seen_start;
  logic        seen_complete;

  logic        fire;
  logic        res_free;
  logic [15:0] count_next;
  logic [15:0] crc_next;
  logic        match_next;
  logic [7:0]  fields_next [4];
  logic [15:0] rx_check;
  logic        frame_good;
  logic        start_next;
  logic        complete_next;
  result_t     verdict;

  assign cfg_ready  = 1'b1;
  assign res_free   = !result_valid || !result_stall;
  assign fire       = in_valid && (!in_item.last_byte || res_free);
  assign item_stall = in_valid && !fire;

  always_comb begin
    count_next  = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;
    crc_next    = (byte_count >= 16'(DELAY_DEPTH)) ?
                  crc_feed(running_crc, delay_line[0]) : running_crc;
    match_next  = header_match;
    fields_next = header_fields;
    case (byte_count)
      16'd0: match_next = (in_item.data_byte == header_byte);
      16'd1: match_next = header_match && (in_item.data_byte == header_byte);
      16'd2: fields_next[0] = in_item.data_byte;
      16'd3: fields_next[1] = in_item.data_byte;
      16'd4: fields_next[2] = in_item.data_byte;
      16'd5: fields_next[3] = in_item.data_byte;
      default: ;
    endcase
    // oldest two held bytes after the shift are the carried CRC
    rx_check   = {delay_line[1], delay_line[2]};
    frame_good = (count_next >= 16'(MIN_FRAME)) && match_next;

    start_next    = seen_start || frame_good;
    complete_next = seen_complete ||
                    (frame_good && (rx_check == crc_next) && (fields_next[0] == fields_next[1]));

    verdict = '0;
    if (count_next < 16'(MIN_FRAME)) begin
      verdict.status = STATUS_SHORT;
    end else if (!match_next) begin
      verdict.status = STATUS_BAD_HEADER;
    end else begin
      verdict.packet_number  = fields_next[0];
      verdict.packet_total   = fields_next[1];
      verdict.payload_length = {fields_next[2], fields_next[3]};
      verdict.received_check = rx_check;
      verdict.computed_check = crc_next;
      verdict.reply_sent     = 1'b1;
      verdict.reply_ok       = (rx_check == crc_next);
      verdict.status         = (rx_check == crc_next) ? STATUS_OK : STATUS_CRC_FAIL;
    end
    verdict.started_flag    = start_next;
    verdict.update_complete = complete_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_byte <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      running_crc   <= CRC_INIT;
      header_match  <= 1'b0;
      seen_start    <= 1'b0;
      seen_complete <= 1'b0;
      for (int i = 0; i < DELAY_DEPTH; i++) delay_line[i] <= '0;
      for (int i = 0; i < 4; i++) header_fields[i] <= '0;
    end else if (fire) begin
      if (in_item.last_byte) begin
        byte_count    <= '0;
        running_crc   <= CRC_INIT;
        header_match  <= 1'b0;
        seen_start    <= start_next;
        seen_complete <= complete_next;
        for (int i = 0; i < DELAY_DEPTH; i++) delay_line[i] <= '0;
        for (int i = 0; i < 4; i++) header_fields[i] <= '0;
      end else begin
        byte_count    <= count_next;
        running_crc   <= crc_next;
        header_match  <= match_next;
        for (int i = 0; i < DELAY_DEPTH - 1; i++) delay_line[i] <= delay_line[i+1];
        delay_line[DELAY_DEPTH-1] <= in_item.data_byte;
        for (int i = 0; i < 4; i++) header_fields[i] <= fields_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && in_item.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_item.last_byte) begin
      result <= verdict;
    end
  end

`ifndef SYNTHESIS
  a_ok_needs_reply: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.reply_ok |-> result.reply_sent && result.status == STATUS_OK)
    else $error("reply_ok without reply_sent");

  a_short_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_SHORT |->
      !result.reply_sent && result.computed_check == 16'h0000)
    else $error("short frame reported fields");

  a_complete_started: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.update_complete |-> result.started_flag)
    else $error("complete without start");

  a_crc_idle: assert property (@(posedge clk) disable iff (rst)
    byte_count == 16'd0 |-> running_crc == CRC_INIT)
    else $error("crc not at init at frame start");
`endif

endmodule
